// ----- rtl/core/bts_pkg.sv -----
package bts_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int SIZE_W    = 13;
    localparam int NEIGH_W   = 4;
    localparam int COUNT_W   = 25;
    localparam int CFG_IDX_W = 2;

    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam int W_CAP    = (MAX_WIDTH > SIZE_MAX) ? SIZE_MAX : MAX_WIDTH;
    localparam int H_CAP    = (MAX_HEIGHT > SIZE_MAX) ? SIZE_MAX : MAX_HEIGHT;
    localparam int COL_W    = $clog2(W_CAP);
    localparam int ROW_W    = $clog2(H_CAP);

    localparam logic [NEIGH_W-1:0] NEIGH_LIMIT = 4'd7;
    localparam logic [NEIGH_W-1:0] STEP_LIMIT  = 4'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NEIGHBOURS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ODD_SUBPASS    = 2'd3;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [NEIGH_W-1:0] min_neighbours;
        logic               odd_subpass;
    } t_cfg;

    typedef struct packed {
        logic               thinned_pixel;
        logic               pixel_changed;
        logic               frame_done;
        logic [COUNT_W-1:0] change_count;
        logic               run_last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_res_pair;

    // Columns hold the above pixel in bit 0, the centre in bit 1 and the below in bit 2.
    function automatic logic thin_decide(
        input logic [2:0]         left,
        input logic [2:0]         mid,
        input logic [2:0]         right,
        input logic [NEIGH_W-1:0] min_n,
        input logic               odd
    );
        logic [7:0]         ring;
        logic [NEIGH_W-1:0] n;
        logic [NEIGH_W-1:0] s;
        logic               prod_a;
        logic               prod_b;
        logic               keep;
        ring = {left[0], left[1], left[2], mid[2], right[2], right[1], right[0], mid[0]};
        n = '0;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + NEIGH_W'(ring[i]);
            if (!ring[i] && ring[(i + 1) & 7]) begin
                s = s + 1'b1;
            end
        end
        if (odd) begin
            prod_a = !(ring[0] & ring[2] & ring[4]);
            prod_b = !(ring[2] & ring[4] & ring[6]);
        end else begin
            prod_a = !(ring[0] & ring[2] & ring[6]);
            prod_b = !(ring[0] & ring[4] & ring[6]);
        end
        keep = 1'b1;
        if (n >= min_n && n < NEIGH_LIMIT && s < STEP_LIMIT && prod_a && prod_b) begin
            keep = 1'b0;
        end
        return mid[1] & keep;
    endfunction

endpackage

// ----- rtl/core/bts_scan.sv -----
module bts_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bts_pkg::t_cfg        i_cfg,
    input  logic                 i_take,
    input  logic [2:0]           i_col,
    output bts_pkg::t_res_pair   o_pair
);

    logic [2:0]                     r_win0, r_win1;
    logic [bts_pkg::COL_W-1:0]      r_col, n_col;
    logic [bts_pkg::ROW_W-1:0]      r_row, n_row;
    logic [bts_pkg::COUNT_W-1:0]    r_seen, n_seen;

    logic [bts_pkg::SIZE_W-1:0]     w_cl, h_cl, w_m1, h_m1;
    logic [bts_pkg::COL_W-1:0]      pc;
    logic                           last_col, last_row, row_border, has_first, interior;
    logic                           pix0, ch0, ch1;
    logic [bts_pkg::COUNT_W-1:0]    cnt_a, cnt_b;
    bts_pkg::t_result               res_a, res_b;

    always_comb begin
        if (i_cfg.image_width < bts_pkg::SIZE_W'(3)) begin
            w_cl = bts_pkg::SIZE_W'(3);
        end else if (i_cfg.image_width > bts_pkg::SIZE_W'(bts_pkg::W_CAP)) begin
            w_cl = bts_pkg::SIZE_W'(bts_pkg::W_CAP);
        end else begin
            w_cl = i_cfg.image_width;
        end
        if (i_cfg.image_height < bts_pkg::SIZE_W'(3)) begin
            h_cl = bts_pkg::SIZE_W'(3);
        end else if (i_cfg.image_height > bts_pkg::SIZE_W'(bts_pkg::H_CAP)) begin
            h_cl = bts_pkg::SIZE_W'(bts_pkg::H_CAP);
        end else begin
            h_cl = i_cfg.image_height;
        end
    end

    assign w_m1       = w_cl - 1'b1;
    assign h_m1       = h_cl - 1'b1;
    assign last_col   = bts_pkg::SIZE_W'(r_col) >= w_m1;
    assign last_row   = bts_pkg::SIZE_W'(r_row) >= h_m1;
    assign row_border = (r_row == '0) || last_row;
    assign has_first  = r_col != '0;
    assign pc         = r_col - 1'b1;
    assign interior   = !row_border && (pc != '0) && (bts_pkg::SIZE_W'(pc) < w_m1);

    assign pix0 = interior ? bts_pkg::thin_decide(r_win0, r_win1, i_col,
                                                  i_cfg.min_neighbours, i_cfg.odd_subpass)
                           : 1'b0;
    assign ch0  = pix0 != r_win1[1];
    assign ch1  = i_col[1];

    assign cnt_a = r_seen + bts_pkg::COUNT_W'(has_first & ch0);
    assign cnt_b = cnt_a + bts_pkg::COUNT_W'(last_col & ch1);

    always_comb begin
        res_a.thinned_pixel = pix0;
        res_a.pixel_changed = ch0;
        res_a.frame_done    = 1'b0;
        res_a.change_count  = cnt_a;
        res_a.run_last      = !last_col;
        res_b.thinned_pixel = 1'b0;
        res_b.pixel_changed = ch1;
        res_b.frame_done    = last_row;
        res_b.change_count  = cnt_b;
        res_b.run_last      = 1'b1;
        o_pair.num    = {1'b0, has_first} + {1'b0, last_col};
        o_pair.first  = has_first ? res_a : res_b;
        o_pair.second = res_b;
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_seen = r_seen;
        if (i_take) begin
            n_seen = (last_col && last_row) ? '0 : cnt_b;
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_seen <= '0;
        end else begin
            if (i_take) begin
                r_win0 <= r_win1;
                r_win1 <= i_col;
            end
            r_col  <= n_col;
            r_row  <= n_row;
            r_seen <= n_seen;
        end
    end

endmodule

// ----- rtl/core/bts_outq.sv -----
module bts_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bts_pkg::t_res_pair   i_pair,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output bts_pkg::t_result     o_data
);

    bts_pkg::t_result            r_mem [bts_pkg::OQ_DEPTH];
    logic [bts_pkg::OQ_AW-1:0]   r_wr, r_rd;
    logic [bts_pkg::OQ_AW:0]     r_cnt;
    logic [1:0]                  push_n;
    logic                        pop;

    assign push_n  = i_push ? i_pair.num : 2'd0;
    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];
    assign o_space = r_cnt <= (bts_pkg::OQ_AW + 1)'(bts_pkg::OQ_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= i_pair.first;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr + 1'b1] <= i_pair.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + bts_pkg::OQ_AW'(push_n);
            r_rd  <= r_rd + bts_pkg::OQ_AW'(pop);
            r_cnt <= r_cnt + (bts_pkg::OQ_AW + 1)'(push_n) - (bts_pkg::OQ_AW + 1)'(pop);
        end
    end

endmodule

// ----- rtl/core/binary_thinning_subpass.sv -----
// The result for a column is queued when the beat of the column to its right is accepted
// and leaves through the result queue; the border result of a row's last column is queued
// by that same beat and leaves behind the result queued before it.
// Throughput: one input beat per cycle if the queue has space, one output beat per cycle
// when the sink is ready; a four-entry queue absorbs the extra result at each row end.
// Reset (synchronous, active low) clears the window, positions, change counter and queue,
// and loads the registers with 640, 480, 2 and 1.
module binary_thinning_subpass (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bts_pkg::SIZE_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_pixel_above,
    input  logic                              i_pixel_centre,
    input  logic                              i_pixel_below,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_thinned_pixel,
    output logic                              o_pixel_changed,
    output logic                              o_frame_done,
    output logic [bts_pkg::COUNT_W-1:0]       o_change_count,
    output logic                              o_run_last
);

    bts_pkg::t_cfg       r_cfg;
    bts_pkg::t_res_pair  pair;
    bts_pkg::t_result    head;
    logic                take;

    assign o_cfg_ready = 1'b1;
    assign take        = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= bts_pkg::SIZE_W'(640);
            r_cfg.image_height   <= bts_pkg::SIZE_W'(480);
            r_cfg.min_neighbours <= bts_pkg::NEIGH_W'(2);
            r_cfg.odd_subpass    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bts_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data;
                end
                bts_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data;
                end
                bts_pkg::CFG_MIN_NEIGHBOURS: begin
                    r_cfg.min_neighbours <= i_cfg_data[bts_pkg::NEIGH_W-1:0];
                end
                bts_pkg::CFG_ODD_SUBPASS: begin
                    r_cfg.odd_subpass <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    bts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .i_col   ({i_pixel_below, i_pixel_centre, i_pixel_above}),
        .o_pair  (pair)
    );

    bts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_pair  (pair),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (head)
    );

    assign o_thinned_pixel = head.thinned_pixel;
    assign o_pixel_changed = head.pixel_changed;
    assign o_frame_done    = head.frame_done;
    assign o_change_count  = head.change_count;
    assign o_run_last      = head.run_last;

endmodule

// ----- rtl/core/bts_check.sv -----
module bts_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_thinned_pixel,
    input logic                              o_pixel_changed,
    input logic                              o_frame_done,
    input logic [bts_pkg::COUNT_W-1:0]       o_change_count,
    input logic                              o_run_last
);

    // A result beat that is held back keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_change_count)
            && $stable(o_thinned_pixel) && $stable(o_frame_done))
        else $error("result beat changed while stalled");

    // Thinning only ever clears pixels.
    a_only_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pixel_changed |-> !o_thinned_pixel)
        else $error("changed pixel is not cleared");

    // The last pixel of a frame is a border pixel and closes its beat.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> !o_thinned_pixel && o_run_last)
        else $error("frame end beat malformed");

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind binary_thinning_subpass bts_check u_bts_check (.*);
